[rtl/feistel_block_cipher_32_macros.svh]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// held off while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_BLOCK_CIPHER_32_MACROS_SVH
`define FEISTEL_BLOCK_CIPHER_32_MACROS_SVH

// Same-cycle implication.
`define FBC32_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fbc32 same-cycle check failed");

// Next-cycle implication.
`define FBC32_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fbc32 next-cycle check failed");

`endif

[rtl/fbc32_pkg.sv]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - package
// Widths, payload types and the byte swap shared across the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbc32_pkg;

  localparam int unsigned HalfW     = 16;
  localparam int unsigned BlkW      = 2 * HalfW;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned KeyRot    = 4;
  localparam int unsigned NumRounds = 4;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [BlkW-1:0]  blk_t;
  typedef logic [KeyW-1:0]  key_t;

  // Swap the two bytes of a half.
  function automatic half_t bswap16(input half_t v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

[rtl/fbc32_in_if.sv]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - input channel
// Valid/ready channel that carries one plaintext item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fbc32_in_if;
  logic                valid;
  logic                ready;
  fbc32_pkg::blk_t     data_block;

  modport source (output valid, output data_block, input ready);
  modport sink   (input valid, input data_block, output ready);
endinterface

[rtl/fbc32_out_if.sv]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - output channel
// Valid/ready channel that carries one transformed item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fbc32_out_if;
  logic                valid;
  logic                ready;
  fbc32_pkg::blk_t     result_block;

  modport source (output valid, output result_block, input ready);
  modport sink   (input valid, input result_block, output ready);
endinterface

[rtl/fbc32_round.sv]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - round
// One round pair: L ^= R + ka, then R ^= L + kb, all modulo 2^16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc32_round (
  input  fbc32_pkg::half_t l_i,
  input  fbc32_pkg::half_t r_i,
  input  fbc32_pkg::half_t ka_i,
  input  fbc32_pkg::half_t kb_i,
  output fbc32_pkg::half_t l_o,
  output fbc32_pkg::half_t r_o
);
  import fbc32_pkg::*;

  half_t l_mix;

  assign l_mix = l_i ^ half_t'(r_i + ka_i);
  assign l_o   = l_mix;
  assign r_o   = r_i ^ half_t'(l_mix + kb_i);

endmodule

[rtl/feistel_block_cipher_32.sv]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - top level
// Four-round 16-bit-half Feistel transform of 32-bit items under a 64-bit key.
// ----------------------------------------------------------------------------
// Each item is held in the input register and then moves to the result
// register, with all four rounds in one combinational pass between them;
// an item stays in the input register while the result register is full
// and not drained. A new item is taken every cycle as long as
// the result side keeps up; when the consumer stalls, the result register and
// then the input register fill, and data_i.ready drops only once both hold an
// item. The key is a plain register written through key_we_i/key_wdata_i and
// must only be changed while no item is in flight. Subkeys are the key rotated
// left by four bits, split into four 16-bit words k1..k4 (k1 highest), used
// as (k1,k2), (k3,k4), (k4,k3), (k2,k1) over the four rounds. Between rounds
// the halves trade places with their bytes swapped; after the last round they
// trade places once more without a swap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "feistel_block_cipher_32_macros.svh"

module feistel_block_cipher_32 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               key_we_i,
  input  fbc32_pkg::key_t    key_wdata_i,
  fbc32_in_if.sink           data_i,
  fbc32_out_if.source        result_o
);
  import fbc32_pkg::*;

  // Key register and subkey schedule (rotation is pure wiring).
  key_t  key_q;
  key_t  rot_key;
  half_t k1, k2, k3, k4;
  half_t ka [NumRounds];
  half_t kb [NumRounds];

  // Input stage.
  logic  s1_valid_q, s1_valid_d;
  blk_t  s1_data_q, s1_data_d;
  logic  s1_adv;
  logic  in_fire;

  // Result stage.
  logic  out_valid_q, out_valid_d;
  blk_t  out_data_q, out_data_d;

  // Round datapath.
  half_t rnd_l_in  [NumRounds];
  half_t rnd_r_in  [NumRounds];
  half_t rnd_l_out [NumRounds];
  half_t rnd_r_out [NumRounds];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_we_i) begin
      key_q <= key_wdata_i;
    end
  end

  assign rot_key = {key_q[KeyW-KeyRot-1:0], key_q[KeyW-1:KeyW-KeyRot]};
  assign k1 = rot_key[4*HalfW-1:3*HalfW];
  assign k2 = rot_key[3*HalfW-1:2*HalfW];
  assign k3 = rot_key[2*HalfW-1:HalfW];
  assign k4 = rot_key[HalfW-1:0];

  assign ka[0] = k1; assign kb[0] = k2;
  assign ka[1] = k3; assign kb[1] = k4;
  assign ka[2] = k4; assign kb[2] = k3;
  assign ka[3] = k2; assign kb[3] = k1;

  // Handshake: advance stage 1 whenever the result register is free or drains.
  assign s1_adv       = !out_valid_q || result_o.ready;
  assign data_i.ready = !s1_valid_q || s1_adv;
  assign in_fire      = data_i.valid && data_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_data_d  = s1_data_q;
    if (data_i.ready) begin
      s1_valid_d = data_i.valid;
      s1_data_d  = data_i.data_block;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Payload register: load only on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= s1_data_d;
    end
  end

  // Four round pairs; cross the halves with a byte swap between them.
  assign rnd_l_in[0] = s1_data_q[BlkW-1:HalfW];
  assign rnd_r_in[0] = s1_data_q[HalfW-1:0];

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    fbc32_round u_round (
      .l_i  (rnd_l_in[g]),
      .r_i  (rnd_r_in[g]),
      .ka_i (ka[g]),
      .kb_i (kb[g]),
      .l_o  (rnd_l_out[g]),
      .r_o  (rnd_r_out[g])
    );
    if (g < NumRounds - 1) begin : g_cross
      assign rnd_l_in[g+1] = bswap16(rnd_r_out[g]);
      assign rnd_r_in[g+1] = bswap16(rnd_l_out[g]);
    end
  end

  // Final trade of halves, no byte swap.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = {rnd_r_out[NumRounds-1], rnd_l_out[NumRounds-1]};
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.result_block = out_data_q;

  // An accepted item lands in the input stage.
  `FBC32_ASSERT_NEXT(a_in_lands, clk_i, rst_ni, in_fire, s1_valid_q)
  // An item in stage 1 moves to the result register when it may.
  `FBC32_ASSERT_NEXT(a_s1_moves, clk_i, rst_ni, s1_valid_q && s1_adv, out_valid_q)
  // A blocked stage 1 keeps its item.
  `FBC32_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !s1_adv,
                     s1_valid_q && $stable(s1_data_q))
  // Never take an item while both stages are full and stalled.
  `FBC32_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, s1_valid_q && !s1_adv, !data_i.ready)

endmodule

[test/fbc32_scoreboard.sv]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - result scoreboard
// Watches the key port and both channels, predicts each result block from
// the current key and checks the block's outputs in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc32_scoreboard (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            key_we_i,
  input  fbc32_pkg::key_t key_wdata_i,
  fbc32_in_if             data_i,
  fbc32_out_if            result_i,
  output int unsigned     mismatch_cnt_o,
  output int unsigned     in_flight_o
);
  import fbc32_pkg::*;

  key_t cur_key;
  blk_t cipher_q [$];

  // Four rounds on 16-bit halves, subkeys from the key rotated left by four.
  function automatic blk_t feistel_encipher(input blk_t blk, input key_t key);
    key_t  rk;
    half_t lh;
    half_t rh;
    half_t tmp;
    half_t ka [NumRounds];
    half_t kb [NumRounds];
    rk = {key[KeyW-KeyRot-1:0], key[KeyW-1:KeyW-KeyRot]};
    ka[0] = rk[63:48]; kb[0] = rk[47:32];
    ka[1] = rk[31:16]; kb[1] = rk[15:0];
    ka[2] = rk[15:0];  kb[2] = rk[31:16];
    ka[3] = rk[47:32]; kb[3] = rk[63:48];
    lh = blk[BlkW-1:HalfW];
    rh = blk[HalfW-1:0];
    for (int r = 0; r < NumRounds; r++) begin
      lh = lh ^ half_t'(rh + ka[r]);
      rh = rh ^ half_t'(lh + kb[r]);
      // Trade halves with bytes swapped, except after the last round.
      if (r != NumRounds - 1) begin
        tmp = {rh[7:0], rh[15:8]};
        rh  = {lh[7:0], lh[15:8]};
        lh  = tmp;
      end
    end
    return {rh, lh};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blk_t want;
    if (!rst_ni) begin
      cur_key = '0;
      cipher_q.delete();
      mismatch_cnt_o = 0;
      in_flight_o = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected result %h, no item in flight",
                   $time, result_i.result_block);
          mismatch_cnt_o++;
        end else begin
          want = cipher_q.pop_front();
          if (result_i.result_block !== want) begin
            $display("%0t: result_block mismatch, expected %h, actual %h",
                     $time, want, result_i.result_block);
            mismatch_cnt_o++;
          end
        end
      end
      if (data_i.valid && data_i.ready) begin
        cipher_q.push_back(feistel_encipher(data_i.data_block, cur_key));
      end
      if (key_we_i) begin
        cur_key = key_wdata_i;
      end
      in_flight_o = cipher_q.size();
    end
  end

endmodule

[test/tb_feistel_block_cipher_32.sv]
// ----------------------------------------------------------------------------
// Feistel block cipher 32 - testbench top
// Drives keys and data blocks with random gaps and back-pressure, including
// a long consumer hold-off and full drains, and reports the verdict from the
// scoreboard's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_feistel_block_cipher_32;
  import fbc32_pkg::*;

  // The input and result registers lie between acceptance and a valid result; leave some margin.
  localparam int unsigned PipeLat    = 2;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned HoldOff    = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        key_we_i;
  key_t        key_wdata_i;
  int unsigned mismatch_cnt;
  int unsigned in_flight;

  // Control shared between the stimulus and the consumer process.
  bit          gaps_on;
  int unsigned sink_hold;

  fbc32_in_if  data_if ();
  fbc32_out_if result_if ();

  feistel_block_cipher_32 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_we_i    (key_we_i),
    .key_wdata_i (key_wdata_i),
    .data_i      (data_if),
    .result_o    (result_if)
  );

  fbc32_scoreboard scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_we_i       (key_we_i),
    .key_wdata_i    (key_wdata_i),
    .data_i         (data_if),
    .result_i       (result_if),
    .mismatch_cnt_o (mismatch_cnt),
    .in_flight_o    (in_flight)
  );

  // 12 ns clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes or a result goes missing.
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one block; entered and left just after a falling edge. Drop valid
  // for the drawn gap first, then hold the block until the block takes it.
  task automatic offer_block(input blk_t value);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      data_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_if.valid      <= 1'b1;
    data_if.data_block <= value;
    do @(posedge clk_i); while (!data_if.ready);
    @(negedge clk_i);
  endtask

  // Drain everything in flight with the sender idle.
  task automatic drain_all();
    data_if.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (PipeLat + 1) @(negedge clk_i);
  endtask

  // Load a new key; only ever done with the pipeline empty.
  task automatic load_key(input key_t value);
    drain_all();
    key_we_i    <= 1'b1;
    key_wdata_i <= value;
    @(negedge clk_i);
    key_we_i    <= 1'b0;
  endtask

  // Consumer: while gaps are on, stall at random before each item, then take the next
  // result. A hold request from the stimulus drops ready for a long stretch
  // so the pipeline fills and back-pressures the sender.
  initial begin
    int unsigned stall;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        result_if.ready <= 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 5) : 0;
        if (stall > 0) begin
          result_if.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        result_if.ready <= 1'b1;
        do @(posedge clk_i); while (!result_if.valid);
        @(negedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    blk_t edge_blocks [6];
    key_t phase_key;
    blk_t value;

    edge_blocks[0] = 32'h0000_0000;
    edge_blocks[1] = 32'hFFFF_FFFF;
    edge_blocks[2] = 32'h8000_0001;
    edge_blocks[3] = 32'h0000_FFFF;
    edge_blocks[4] = 32'hFFFF_0000;
    edge_blocks[5] = 32'hA5A5_5A5A;

    rst_ni             = 1'b0;
    key_we_i           = 1'b0;
    key_wdata_i        = '0;
    data_if.valid      = 1'b0;
    data_if.data_block = '0;
    gaps_on            = 1'b1;
    sink_hold          = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: edge blocks under the reset key, all-ones key, and a key
    // whose top nibble wraps around in the rotation.
    foreach (edge_blocks[i]) offer_block(edge_blocks[i]);
    load_key('1);
    foreach (edge_blocks[i]) offer_block(edge_blocks[i]);
    load_key(64'hF123_4567_89AB_CDEF);
    foreach (edge_blocks[i]) offer_block(edge_blocks[i]);

    // Random phases, each under its own key.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        2:       phase_key = '1;
        4:       phase_key = '0;
        default: phase_key = {$urandom(), $urandom()};
      endcase
      load_key(phase_key);
      // Run one phase back to back with no idling on either side.
      gaps_on = (p != 1);
      // Stall the consumer hard at the start of this phase.
      if (p == 3) sink_hold = HoldOff;
      for (int n = 0; n < PhaseItems; n++) begin
        value = ($urandom_range(0, 15) == 0) ? edge_blocks[$urandom_range(0, 5)]
                                             : blk_t'($urandom());
        offer_block(value);
        // Pause the sender mid-phase until every result is back.
        if (p == 4 && n == PhaseItems / 2) drain_all();
      end
    end
    gaps_on = 1'b1;

    drain_all();
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
